>>> src/eec_pkg.sv
// Shared types, codes and constants for the EEPROM controller register block.
package eec_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TICK_W  = 20;
    localparam int unsigned CTRL_W  = 6;
    localparam int unsigned ECNT_W  = 3;
    localparam int unsigned CFG_AW  = 5;
    localparam int unsigned CFG_DW  = 32;

    // transaction opcodes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_SLEEP = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    // register selects
    localparam logic [1:0] SEL_ADDR_LO = 2'd0;
    localparam logic [1:0] SEL_ADDR_HI = 2'd1;
    localparam logic [1:0] SEL_DATA    = 2'd2;
    localparam logic [1:0] SEL_CTRL    = 2'd3;

    // control register bit positions
    localparam int unsigned B_EERE  = 0;
    localparam int unsigned B_EEPE  = 1;
    localparam int unsigned B_EEMPE = 2;
    localparam int unsigned B_EERIE = 3;

    // programming modes
    localparam logic [1:0] PM_ERASE_WRITE = 2'd0;
    localparam logic [1:0] PM_ERASE_ONLY  = 2'd1;
    localparam logic [1:0] PM_WRITE_ONLY  = 2'd2;
    localparam logic [1:0] PM_RESERVED    = 2'd3;

    // layout versions
    localparam logic [1:0] VER_NO_IRQ  = 2'd1;
    localparam logic [1:0] VER_NO_MODE = 2'd2;

    // warning codes
    localparam logic [3:0] W_NONE         = 4'd0;
    localparam logic [3:0] W_WR_BUSY      = 4'd1;
    localparam logic [3:0] W_MODE_BUSY    = 4'd2;
    localparam logic [3:0] W_MODE_RSVD    = 4'd3;
    localparam logic [3:0] W_READ_PROG    = 4'd4;
    localparam logic [3:0] W_NO_MASTER    = 4'd5;
    localparam logic [3:0] W_MASTER_BUSY  = 4'd6;
    localparam logic [3:0] W_RD_BUSY      = 4'd7;
    localparam logic [3:0] W_PROG_RSVD    = 4'd8;
    localparam logic [3:0] W_SET_BITS     = 4'd9;

    // configuration register indexes
    localparam logic [2:0] CFG_VERSION  = 3'd0;
    localparam logic [2:0] CFG_SIM_TIME = 3'd1;
    localparam logic [2:0] CFG_ATOMIC   = 3'd2;
    localparam logic [2:0] CFG_ERASE    = 3'd3;
    localparam logic [2:0] CFG_WRITE    = 3'd4;

    localparam logic [ECNT_W-1:0] ENABLE_TICKS = 3'd4;
    localparam logic [CTRL_W-1:0] CTRL_KEEP_BUSY = 6'h32;
    localparam logic [TICK_W-1:0] ATOMIC_RST = 20'd68000;
    localparam logic [TICK_W-1:0] ERASE_RST  = 20'd36000;
    localparam logic [TICK_W-1:0] WRITE_RST  = 20'd36000;
    localparam logic [DATA_W-1:0] ERASED     = 8'hFF;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] wdata;
        logic              sleep_deep;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              busy_res;
        logic [3:0]        warning;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // control bits kept from a written byte for each layout version
    function automatic logic [CTRL_W-1:0] ctrl_mask(input logic [1:0] ver);
        logic [CTRL_W-1:0] m;
        m = 6'h3F;
        if (ver == VER_NO_IRQ) begin
            m = 6'h07;
        end else if (ver == VER_NO_MODE) begin
            m = 6'h0F;
        end
        return m;
    endfunction

endpackage

>>> src/eec_if.sv
// Valid/ready channel carrying one payload item per transaction.
interface eec_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/eeprom_controller_registers.sv
// EEPROM controller: address, data and control registers over a byte cell memory.
// Each accepted transaction is registered and executed in the S_EXEC state, and its
// result is registered in r_out. The cell read at accept and the write-back in the
// execute state hold off the next transaction, accepted only back in S_IDLE.
// Reset: synchronous; a clearing pass then writes every cell to 0xFF, during which
// no transaction is accepted (configuration writes still are).
module eeprom_controller_registers
    import eec_pkg::*;
#(
    parameter int unsigned SIZE = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eec_if.sink               i_in,
    eec_if.source             o_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0] o_prdata,
    output logic              o_pready
);
    localparam int unsigned AW = $clog2(SIZE);
    localparam logic [15:0] AMASK = 16'(SIZE - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr;

    logic [1:0]         r_version;
    logic               r_sim_time;
    logic [TICK_W-1:0]  r_atomic_ticks, r_erase_ticks, r_write_ticks;

    logic [DATA_W-1:0]  r_addr_lo, n_addr_lo;
    logic [DATA_W-1:0]  r_addr_hi, n_addr_hi;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [CTRL_W-1:0]  r_ctrl, n_ctrl;
    logic [ECNT_W-1:0]  r_en_cnt, n_en_cnt;
    logic [TICK_W-1:0]  r_busy_cnt, n_busy_cnt;
    logic               r_asleep, n_asleep;

    t_in_item           r_item;
    t_out_item          r_out, n_out;
    logic               r_out_valid;

    logic               in_accept;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [15:0]        cur_addr;
    logic               addr_ok;
    logic [DATA_W-1:0]  cell_rd;
    logic [DATA_W-1:0]  cell_new;
    logic               cell_we;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;

    assign cur_addr  = {r_addr_hi, r_addr_lo};
    assign addr_ok   = ({1'b0, cur_addr} < 17'(SIZE));
    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Cell memory: read at accept, write back in the execute cycle or clear sweep
    assign ram_we    = (r_state == S_CLEAR) || cell_we;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : cur_addr[AW-1:0];
    assign ram_wdata = (r_state == S_CLEAR) ? ERASED : cell_new;

    eec_ram #(
        .WIDTH(DATA_W),
        .DEPTH(SIZE)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(cur_addr[AW-1:0]),
        .o_rdata(cell_rd)
    );

    // Configuration port
    assign o_pready = 1'b1;
    assign cfg_idx  = i_paddr[4:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_comb begin
        o_prdata = '0;
        unique case (cfg_idx)
            CFG_VERSION:  o_prdata = CFG_DW'(r_version);
            CFG_SIM_TIME: o_prdata = CFG_DW'(r_sim_time);
            CFG_ATOMIC:   o_prdata = CFG_DW'(r_atomic_ticks);
            CFG_ERASE:    o_prdata = CFG_DW'(r_erase_ticks);
            CFG_WRITE:    o_prdata = CFG_DW'(r_write_ticks);
            default:      o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version      <= 2'd3;
            r_sim_time     <= 1'b0;
            r_atomic_ticks <= ATOMIC_RST;
            r_erase_ticks  <= ERASE_RST;
            r_write_ticks  <= WRITE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_VERSION:  r_version      <= i_pwdata[1:0];
                CFG_SIM_TIME: r_sim_time     <= i_pwdata[0];
                CFG_ATOMIC:   r_atomic_ticks <= i_pwdata[TICK_W-1:0];
                CFG_ERASE:    r_erase_ticks  <= i_pwdata[TICK_W-1:0];
                CFG_WRITE:    r_write_ticks  <= i_pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Execute one transaction against the registers and the cell read back
    always_comb begin
        logic [3:0]        warn;
        logic [DATA_W-1:0] rd;
        logic [CTRL_W-1:0] d;
        logic              busy;
        logic [TICK_W-1:0] ticks;
        logic [DATA_W-1:0] wd;

        n_addr_lo  = r_addr_lo;
        n_addr_hi  = r_addr_hi;
        n_data     = r_data;
        n_ctrl     = r_ctrl;
        n_en_cnt   = r_en_cnt;
        n_busy_cnt = r_busy_cnt;
        n_asleep   = r_asleep;
        cell_we    = 1'b0;
        cell_new   = cell_rd;
        warn       = W_NONE;
        rd         = '0;
        ticks      = '0;
        wd         = r_item.wdata;
        d          = wd[CTRL_W-1:0] & ctrl_mask(r_version);
        busy       = r_ctrl[B_EEPE];

        if (r_state == S_EXEC) begin
            case (r_item.op)
                OP_WRITE: begin
                    if (r_item.reg_sel == SEL_CTRL) begin
                        if (d[5:4] != r_ctrl[5:4]) begin
                            if (busy) begin
                                if (warn == W_NONE) warn = W_MODE_BUSY;
                            end else begin
                                if (d[5:4] == PM_RESERVED && warn == W_NONE) warn = W_MODE_RSVD;
                                n_ctrl[5:4] = d[5:4];
                            end
                        end
                        n_ctrl[B_EERIE] = d[B_EERIE];

                        if (d[B_EEPE]) begin
                            if (d[B_EERE]) begin
                                if (warn == W_NONE) warn = W_READ_PROG;
                            end else if (!r_ctrl[B_EEMPE]) begin
                                if (warn == W_NONE) warn = W_NO_MASTER;
                            end else if (addr_ok) begin
                                case (n_ctrl[5:4])
                                    PM_ERASE_WRITE: begin
                                        cell_we  = 1'b1;
                                        cell_new = r_data;
                                        ticks    = r_atomic_ticks;
                                    end
                                    PM_ERASE_ONLY: begin
                                        cell_we  = 1'b1;
                                        cell_new = ERASED;
                                        ticks    = r_erase_ticks;
                                    end
                                    PM_WRITE_ONLY: begin
                                        if ((r_data & ~cell_rd) != '0 && warn == W_NONE) begin
                                            warn = W_SET_BITS;
                                        end
                                        cell_we  = 1'b1;
                                        cell_new = r_data & cell_rd;
                                        ticks    = r_write_ticks;
                                    end
                                    default: begin
                                        if (warn == W_NONE) warn = W_PROG_RSVD;
                                    end
                                endcase
                                if (r_sim_time && ticks != '0) begin
                                    n_ctrl[B_EEPE] = 1'b1;
                                    n_busy_cnt     = ticks;
                                end
                            end
                        end

                        if (d[B_EEPE] || !d[B_EEMPE]) begin
                            n_ctrl[B_EEMPE] = 1'b0;
                            n_en_cnt        = '0;
                        end else if (busy) begin
                            if (warn == W_NONE) warn = W_MASTER_BUSY;
                        end else begin
                            n_ctrl[B_EEMPE] = 1'b1;
                            n_en_cnt        = ENABLE_TICKS;
                        end

                        if (d[B_EERE] && !d[B_EEPE]) begin
                            if (busy) begin
                                if (warn == W_NONE) warn = W_RD_BUSY;
                            end else if (addr_ok) begin
                                n_data = cell_rd;
                            end
                        end
                        n_ctrl[B_EERE] = 1'b0;
                    end else if (busy) begin
                        warn = W_WR_BUSY;
                    end else begin
                        case (r_item.reg_sel)
                            SEL_ADDR_LO: n_addr_lo = wd & AMASK[7:0];
                            SEL_ADDR_HI: n_addr_hi = wd & AMASK[15:8];
                            default:     n_data    = wd;
                        endcase
                    end
                end
                OP_READ: begin
                    case (r_item.reg_sel)
                        SEL_ADDR_LO: rd = r_addr_lo;
                        SEL_ADDR_HI: rd = r_addr_hi;
                        SEL_DATA:    rd = r_data;
                        default:     rd = DATA_W'(r_ctrl);
                    endcase
                end
                OP_TICK: begin
                    if (r_en_cnt != '0) begin
                        n_en_cnt = r_en_cnt - 3'd1;
                        if (r_en_cnt == 3'd1) n_ctrl[B_EEMPE] = 1'b0;
                    end
                    if (r_busy_cnt != '0) begin
                        n_busy_cnt = r_busy_cnt - 20'd1;
                        if (r_busy_cnt == 20'd1) n_ctrl[B_EEPE] = 1'b0;
                    end
                end
                OP_SLEEP: begin
                    n_asleep = r_item.sleep_deep;
                end
                OP_RESET: begin
                    n_asleep  = 1'b0;
                    // a running program keeps its busy bit and mode
                    n_ctrl    = busy ? (r_ctrl & CTRL_KEEP_BUSY) : '0;
                    n_addr_lo = '0;
                    n_addr_hi = '0;
                    n_data    = '0;
                    n_en_cnt  = '0;
                end
                default: ;
            endcase
        end

        n_out.read_data = rd;
        n_out.busy_res  = n_ctrl[B_EEPE];
        n_out.irq       = n_ctrl[B_EERIE] && !n_ctrl[B_EEPE] && !n_asleep;
        n_out.warning   = warn;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(SIZE - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_addr_lo   <= '0;
            r_addr_hi   <= '0;
            r_data      <= '0;
            r_ctrl      <= '0;
            r_en_cnt    <= '0;
            r_busy_cnt  <= '0;
            r_asleep    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_addr_lo  <= n_addr_lo;
            r_addr_hi  <= n_addr_hi;
            r_data     <= n_data;
            r_ctrl     <= n_ctrl;
            r_en_cnt   <= n_en_cnt;
            r_busy_cnt <= n_busy_cnt;
            r_asleep   <= n_asleep;
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in.data;
        end
        if (r_state == S_EXEC) begin
            r_out <= n_out;
        end
    end

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl[B_EEPE] == (r_busy_cnt != '0))
        else $error("busy bit and busy countdown disagree");

    a_master_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl[B_EEMPE] == (r_en_cnt != '0))
        else $error("master enable and its countdown disagree");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_out_valid)
        else $error("executed transaction produced no result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (!r_out_valid || o_out.ready) && r_state != S_CLEAR)
        else $error("transaction accepted while result slot or memory is not free");
endmodule

>>> src/eec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module eec_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
